@@ design/jsu_pkg.sv @@
package jsu_pkg;

  localparam int unsigned MAX_CAPACITY_DEF = 4096;
  localparam int unsigned CAP_W            = 13;
  localparam int unsigned LEN_W            = 12;
  localparam int unsigned LIMIT_W          = 17;
  localparam logic [CAP_W-1:0] CAP_RESET   = 13'd513;
  localparam logic [LIMIT_W-1:0] LEN_MAX   = 17'd4095;

  // byte slots of one queued request: 'u' plus three held digits plus the current byte
  localparam int unsigned SLOTS       = 5;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  typedef struct packed {
    logic [SLOTS-1:0][7:0] bytes;
    logic [SLOT_W-1:0]     n_bytes;
    logic                  done;
    logic                  found;
    logic [LEN_W-1:0]      length;
  } jsu_cmd_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_of(logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  // largest number of bytes stored for a given capacity
  function automatic logic [LEN_W-1:0] limit_of(logic [CAP_W-1:0] cap, int unsigned max_cap);
    logic [LIMIT_W-1:0] c;
    logic [LIMIT_W-1:0] m;
    c = LIMIT_W'(cap);
    m = LIMIT_W'(max_cap);
    if (c == '0) c = LIMIT_W'(1);
    if (c > m) c = m;
    c = c - LIMIT_W'(1);
    if (c > LEN_MAX) c = LEN_MAX;
    return c[LEN_W-1:0];
  endfunction

endpackage

@@ design/jsu_ifs.sv @@
interface jsu_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_end;
  modport source(output valid, output in_byte, output line_end, input ready);
  modport sink(input valid, input in_byte, input line_end, output ready);
endinterface

interface jsu_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_done;
  logic        string_found;
  logic [11:0] length;
  logic        last_of_run;
  modport source(output valid, output out_byte, output is_done, output string_found,
                 output length, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input is_done, input string_found,
               input length, input last_of_run, output ready);
endinterface

interface jsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/jsu_front.sv @@
module jsu_front #(
  parameter int unsigned MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  jsu_item_if.sink          item,
  jsu_cfg_if.sink           cfg,
  input  logic              full,
  output logic              push,
  output jsu_pkg::jsu_cmd_t cmd
);
  import jsu_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_STR  = 5'b00010,
    PH_ESC  = 5'b00100,
    PH_HEX  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  phase_t           phase, phase_next;
  logic [2:0][7:0]  hex_digits, hex_digits_next;
  logic [1:0]       hex_count, hex_count_next;
  logic [3:0]       hex_value, hex_value_next;
  logic [LEN_W-1:0] out_count, out_count_next;
  logic [LEN_W-1:0] limit;

  logic [SLOTS-1:0][7:0] att;
  logic [SLOT_W-1:0]     att_n;
  logic [SLOT_W-1:0]     n_store;
  logic [LEN_W-1:0]      room;
  logic [LEN_W-1:0]      oc_after;
  logic                  str_byte;
  logic                  done;
  logic                  found;
  logic                  accept;
  logic [7:0]            b;
  logic                  last;
  hex_t                  hx;

  assign item.ready = !full;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;
  assign b          = item.in_byte;
  assign last       = item.line_end;
  assign hx         = hex_of(b);

  always_comb begin
    phase_next      = phase;
    hex_digits_next = hex_digits;
    hex_count_next  = hex_count;
    hex_value_next  = hex_value;
    att             = '0;
    att_n           = '0;
    str_byte        = 1'b0;
    done            = 1'b0;
    found           = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (b == CH_SPACE || b == CH_TAB) begin
          phase_next = PH_IDLE;
        end else if (b == CH_QUOTE) begin
          phase_next = PH_STR;
        end else begin
          done       = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_STR: begin
        str_byte = 1'b1;
      end
      PH_ESC: begin
        phase_next = PH_STR;
        att_n      = SLOT_W'(1);
        if (b == CH_LOW_N) begin
          att[0] = CH_LF;
        end else if (b == CH_LOW_R) begin
          att[0] = CH_CR;
        end else if (b == CH_LOW_T) begin
          att[0] = CH_TAB;
        end else if (b == CH_LOW_U && !last) begin
          att_n          = '0;
          phase_next     = PH_HEX;
          hex_count_next = '0;
          hex_value_next = '0;
        end else begin
          att[0] = b;
        end
      end
      PH_HEX: begin
        if (!hx.bad && hex_count == 2'd3) begin
          att[0]     = {hex_value, hx.val};
          att_n      = SLOT_W'(1);
          phase_next = PH_STR;
        end else if (!hx.bad && !last) begin
          hex_digits_next[hex_count] = b;
          hex_value_next             = hx.val;
          hex_count_next             = hex_count + 2'd1;
        end else begin
          // replay the escape as literal text, then treat this byte as a plain one
          phase_next     = PH_STR;
          att[0]         = CH_LOW_U;
          att[1]         = hex_digits[0];
          att[2]         = hex_digits[1];
          att[3]         = hex_digits[2];
          att_n          = SLOT_W'(1) + SLOT_W'(hex_count);
          hex_count_next = '0;
          hex_value_next = '0;
          str_byte       = 1'b1;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (str_byte) begin
      if (b == CH_QUOTE) begin
        done       = 1'b1;
        found      = 1'b1;
        phase_next = PH_DONE;
      end else if (b == CH_BSLASH && !last) begin
        phase_next = PH_ESC;
      end else begin
        att[att_n] = b;
        att_n      = att_n + SLOT_W'(1);
      end
    end

    if (last) begin
      if (phase_next != PH_DONE) begin
        done  = 1'b1;
        found = (phase_next != PH_IDLE);
      end
      phase_next     = PH_IDLE;
      hex_count_next = '0;
      hex_value_next = '0;
    end
  end

  // stores beyond the limit are dropped
  always_comb begin
    room     = (out_count < limit) ? (limit - out_count) : '0;
    n_store  = (room < LEN_W'(att_n)) ? room[SLOT_W-1:0] : att_n;
    oc_after = out_count + LEN_W'(n_store);
    if (phase == PH_IDLE || last) begin
      out_count_next = '0;
    end else begin
      out_count_next = oc_after;
    end
  end

  assign push        = accept && (n_store != '0 || done);
  assign cmd.bytes   = att;
  assign cmd.n_bytes = n_store;
  assign cmd.done    = done;
  assign cmd.found   = found;
  assign cmd.length  = oc_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hex_count <= '0;
      hex_value <= '0;
      out_count <= '0;
      limit     <= limit_of(CAP_RESET, MAX_CAPACITY);
    end else begin
      if (accept) begin
        phase      <= phase_next;
        hex_count  <= hex_count_next;
        hex_value  <= hex_value_next;
        out_count  <= out_count_next;
      end
      if (cfg.valid && cfg.ready) begin
        limit <= limit_of(cfg.data, MAX_CAPACITY);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hex_digits <= hex_digits_next;
    end
  end

endmodule

@@ design/jsu_fifo.sv @@
module jsu_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsu_pkg::jsu_cmd_t wr_cmd,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output jsu_pkg::jsu_cmd_t rd_cmd
);
  import jsu_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  jsu_cmd_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full     = (count == (PW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

endmodule

@@ design/jsu_back.sv @@
module jsu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  jsu_pkg::jsu_cmd_t q_cmd,
  output logic              pop,
  jsu_result_if.source      result
);
  import jsu_pkg::*;

  jsu_cmd_t cur;
  logic     cur_valid;
  logic     is_byte;
  logic     fin;
  logic     take;

  assign is_byte = (cur.n_bytes != '0);
  assign fin     = is_byte ? (cur.n_bytes == SLOT_W'(1) && !cur.done) : 1'b1;
  assign take    = result.valid && result.ready;
  assign pop     = q_valid && (!cur_valid || (take && fin));

  assign result.valid        = cur_valid;
  assign result.out_byte     = is_byte ? cur.bytes[0] : 8'h00;
  assign result.is_done      = !is_byte;
  assign result.string_found = is_byte ? 1'b0 : cur.found;
  assign result.length       = is_byte ? '0 : cur.length;
  assign result.last_of_run  = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (take && fin) begin
      cur_valid <= 1'b0;
    end
  end

  // advance through the byte slots, then the done result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_cmd;
    end else if (take && !fin) begin
      cur.bytes   <= cur.bytes >> 8;
      cur.n_bytes <= cur.n_bytes - SLOT_W'(1);
    end
  end

endmodule

@@ design/json_string_unescape.sv @@
// Streaming JSON string decoder: one raw byte of the text after a key's colon is taken
// per request, with line_end on the final byte, and decoded bytes come out one per
// request followed by a done result that carries the length and the found flag. A new
// input byte can be taken every cycle while the queue is not full; a four-entry queue
// between decoder and output stage absorbs the bursts of a byte that yields several
// results (a failed \u escape replays up to five bytes plus done) before input ready
// drops. Output sets the rate: one result per cycle while result ready is high. The user
// must write the capacity register only while no line is in flight; the block won't check.
module json_string_unescape #(
  parameter int unsigned MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  jsu_item_if.sink     item,
  jsu_cfg_if.sink      cfg,
  jsu_result_if.source result
);
  import jsu_pkg::*;

  jsu_cmd_t front_cmd;
  jsu_cmd_t head_cmd;
  logic     push;
  logic     pop;
  logic     full;
  logic     nonempty;

  jsu_front #(
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .item(item),
    .cfg (cfg),
    .full(full),
    .push(push),
    .cmd (front_cmd)
  );

  jsu_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_cmd  (front_cmd),
    .pop     (pop),
    .full    (full),
    .nonempty(nonempty),
    .rd_cmd  (head_cmd)
  );

  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(nonempty),
    .q_cmd  (head_cmd),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ dv/jsu_decode_checker.sv @@
`timescale 1ns / 100ps

module jsu_decode_checker (
  input  logic  clk,
  input  logic  rst,
  jsu_item_if   item,
  jsu_cfg_if    cfg,
  jsu_result_if result,
  output int    fail_count,
  output int    outstanding
);
  import jsu_pkg::*;

  typedef enum logic [4:0] {
    SCAN_IDLE = 5'b00001,
    SCAN_STR  = 5'b00010,
    SCAN_ESC  = 5'b00100,
    SCAN_HEX  = 5'b01000,
    SCAN_DONE = 5'b10000
  } scan_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_done;
    logic             string_found;
    logic [LEN_W-1:0] length;
    logic             last_of_run;
  } decoded_t;

  localparam int PRINT_CAP = 40;

  logic [CAP_W-1:0] capacity;
  scan_t            scan;
  logic [7:0]       held_digit [3];
  logic [1:0]       hex_n;
  logic [7:0]       hex_acc;
  logic [LEN_W-1:0] emitted;
  decoded_t         burst [$];
  decoded_t         expected_decode [$];
  int               fails = 0;

  function automatic int unsigned stored_limit();
    int unsigned c;
    c = capacity;
    if (c == 0) c = 1;
    if (c > MAX_CAPACITY_DEF) c = MAX_CAPACITY_DEF;
    c = c - 1;
    if (c > (1 << LEN_W) - 1) c = (1 << LEN_W) - 1;
    return c;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    return 5'h10;
  endfunction

  task automatic add_result(input logic [7:0] b, input logic done, input logic found,
                            input logic [LEN_W-1:0] len);
    decoded_t r;
    r.out_byte     = b;
    r.is_done      = done;
    r.string_found = found;
    r.length       = len;
    r.last_of_run  = 1'b0;
    burst.push_back(r);
  endtask

  // drop bytes beyond the buffer limit
  task automatic keep_byte(input logic [7:0] b);
    if (emitted < stored_limit()) begin
      add_result(b, 1'b0, 1'b0, '0);
      emitted = emitted + 1'b1;
    end
  endtask

  task automatic string_char(input logic [7:0] b, input logic last);
    if (b == CH_QUOTE) begin
      add_result(8'h00, 1'b1, 1'b1, emitted);
      scan = SCAN_DONE;
    end else if (b == CH_BSLASH && !last) begin
      scan = SCAN_ESC;
    end else begin
      keep_byte(b);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [4:0] d;
    decoded_t   r;
    burst.delete();
    case (scan)
      SCAN_IDLE: begin
        if (b == CH_SPACE || b == CH_TAB) begin
        end else if (b == CH_QUOTE) begin
          scan    = SCAN_STR;
          emitted = '0;
        end else begin
          add_result(8'h00, 1'b1, 1'b0, '0);
          scan = SCAN_DONE;
        end
      end
      SCAN_STR: string_char(b, last);
      SCAN_ESC: begin
        scan = SCAN_STR;
        if (b == CH_LOW_N) keep_byte(CH_LF);
        else if (b == CH_LOW_R) keep_byte(CH_CR);
        else if (b == CH_LOW_T) keep_byte(CH_TAB);
        else if (b == CH_LOW_U && !last) begin
          scan    = SCAN_HEX;
          hex_n   = '0;
          hex_acc = '0;
        end else keep_byte(b);
      end
      SCAN_HEX: begin
        d = nibble_of(b);
        if (!d[4] && hex_n == 2'd3) begin
          keep_byte({hex_acc[3:0], d[3:0]});
          scan = SCAN_STR;
        end else if (!d[4] && hex_n < 2'd3 && !last) begin
          held_digit[hex_n] = b;
          hex_acc           = {hex_acc[3:0], d[3:0]};
          hex_n             = hex_n + 1'b1;
        end else begin
          // replay the broken escape, then treat this byte as plain string data
          scan = SCAN_STR;
          keep_byte(CH_LOW_U);
          for (int k = 0; k < hex_n; k++) keep_byte(held_digit[k]);
          hex_n   = '0;
          hex_acc = '0;
          string_char(b, last);
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      if (scan != SCAN_DONE) add_result(8'h00, 1'b1, scan != SCAN_IDLE, emitted);
      scan       = SCAN_IDLE;
      emitted    = '0;
      hex_n      = '0;
      hex_acc    = '0;
      held_digit = '{8'h00, 8'h00, 8'h00};
    end

    if (burst.size() > 0) begin
      r = burst.pop_back();
      r.last_of_run = 1'b1;
      burst.push_back(r);
    end
    foreach (burst[i]) expected_decode.push_back(burst[i]);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fails < PRINT_CAP) begin
      $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    end
    fails++;
  endtask

  task automatic check_result();
    decoded_t want;
    if (expected_decode.size() == 0) begin
      report_mismatch("result with nothing pending, out_byte", result.out_byte, 0);
      return;
    end
    want = expected_decode.pop_front();
    if (result.out_byte !== want.out_byte)
      report_mismatch("out_byte", result.out_byte, want.out_byte);
    if (result.is_done !== want.is_done)
      report_mismatch("is_done", result.is_done, want.is_done);
    if (result.string_found !== want.string_found)
      report_mismatch("string_found", result.string_found, want.string_found);
    if (result.length !== want.length)
      report_mismatch("length", result.length, want.length);
    if (result.last_of_run !== want.last_of_run)
      report_mismatch("last_of_run", result.last_of_run, want.last_of_run);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity   = CAP_RESET;
      scan       = SCAN_IDLE;
      held_digit = '{8'h00, 8'h00, 8'h00};
      hex_n      = '0;
      hex_acc    = '0;
      emitted    = '0;
      expected_decode.delete();
    end else begin
      if (cfg.valid && cfg.ready) capacity = cfg.data;
      // predict before checking, so an answer never arrives ahead of its expectation
      if (item.valid && item.ready) decode_byte(item.in_byte, item.line_end);
      if (result.valid && result.ready) check_result();
    end
    fail_count  <= fails;
    outstanding <= expected_decode.size();
  end

endmodule

@@ dv/json_string_unescape_test.sv @@
`timescale 1ns / 100ps

module json_string_unescape_test;
  import jsu_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 32;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 10;
  localparam int LONG_LINE      = 12;

  logic clk;
  logic rst;

  jsu_item_if   item_ch ();
  jsu_cfg_if    cfg_ch ();
  jsu_result_if result_ch ();

  int         fail_count;
  int         outstanding;
  int         items_sent = 0;
  bit         hold_output = 1'b0;
  bit         hold_active = 1'b0;
  bit         sender_calm = 1'b0;
  bit         receiver_calm = 1'b0;
  logic [7:0] line_bytes [$];

  json_string_unescape dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (result_ch)
  );

  jsu_decode_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .cfg         (cfg_ch),
    .result      (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none at all while calm
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] printable();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 126)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.in_byte  <= b;
    item_ch.line_end <= last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_item(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  // drain everything, then give bytes that yield no result time to clear
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic make_line();
    int         n;
    int         kind;
    int         r;
    logic [7:0] b;
    line_bytes.delete();
    // noise line
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 5);
      repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    line_bytes.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : CH_QUOTE);
    n = $urandom_range(0, 12);
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        line_bytes.push_back(printable());
      end else if (kind < 63) begin
        line_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 73) begin
        line_bytes.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: line_bytes.push_back(CH_LOW_N);
          1: line_bytes.push_back(CH_LOW_R);
          default: line_bytes.push_back(CH_LOW_T);
        endcase
      end else if (kind < 81) begin
        line_bytes.push_back(CH_BSLASH);
        line_bytes.push_back(CH_LOW_U);
        repeat (4) line_bytes.push_back(hex_char());
      end else if (kind < 88) begin
        // broken escape: too few digits, then a non-hex byte
        line_bytes.push_back(CH_BSLASH);
        line_bytes.push_back(CH_LOW_U);
        repeat ($urandom_range(0, 3)) line_bytes.push_back(hex_char());
        case ($urandom_range(0, 4))
          0: b = CH_QUOTE;
          1: b = CH_BSLASH;
          2: b = 8'h67;
          3: b = 8'h47;
          default: b = 8'($urandom_range(128, 255));
        endcase
        line_bytes.push_back(b);
      end else if (kind < 94) begin
        line_bytes.push_back(CH_BSLASH);
        line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        line_bytes.push_back(CH_BSLASH);
        line_bytes.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 75) begin
      line_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 2)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (r < 85) begin
      line_bytes.push_back(CH_BSLASH);
    end else if (r < 93) begin
      line_bytes.push_back(CH_BSLASH);
      line_bytes.push_back(CH_LOW_U);
      repeat ($urandom_range(0, 3)) line_bytes.push_back(hex_char());
    end
  endtask

  task automatic run_lines(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      make_line();
      send_line();
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_active = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
        hold_active = 1'b0;
      end else begin
        gap = pick_gap(receiver_calm);
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || rst) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CAP_W-1:0] cap_plan [9];
    cap_plan = '{13'd1, 13'd0, 13'd2, 13'd3, 13'd8191, 13'd4096, 13'd4095, 13'd5, 13'd7};
    rst = 1'b1;
    item_ch.valid    <= 1'b0;
    item_ch.in_byte  <= 8'h00;
    item_ch.line_end <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines at the reset capacity
    line_bytes = '{CH_TAB, CH_QUOTE, CH_BSLASH, CH_LOW_R, CH_BSLASH, CH_LOW_U, 8'h30, 8'h30,
                   8'h66, 8'h46, CH_QUOTE, 8'h78};
    send_line();
    line_bytes = '{8'h78};
    send_line();
    line_bytes = '{CH_SPACE};
    send_line();
    line_bytes = '{CH_QUOTE, CH_BSLASH, CH_LOW_U, 8'h31, 8'h67, CH_BSLASH, CH_QUOTE, CH_BSLASH};
    send_line();
    line_bytes = '{CH_QUOTE, CH_BSLASH, CH_LOW_U, 8'h31, 8'h32};
    send_line();
    line_bytes = '{CH_QUOTE, CH_BSLASH, CH_LOW_U};
    send_line();
    line_bytes = '{CH_QUOTE, 8'h00, 8'hFF, CH_QUOTE};
    send_line();

    for (int p = 0; p < 9; p++) begin
      settle();
      write_capacity(p == 8 ? CAP_W'($urandom_range(1, 12)) : cap_plan[p]);
      sender_calm   = (p == 5 || p == 6);
      receiver_calm = (p == 5);
      if (p == 6) begin
        // long string while the output is held: the queue fills and input stalls
        hold_output = 1'b1;
        wait (hold_active);
        line_bytes.delete();
        line_bytes.push_back(CH_QUOTE);
        repeat (LONG_LINE) line_bytes.push_back(printable());
        send_line();
      end
      run_lines(PHASE_ITEMS);
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/jsu_pkg.sv
design/jsu_ifs.sv
design/jsu_front.sv
design/jsu_fifo.sv
design/jsu_back.sv
design/json_string_unescape.sv
dv/jsu_decode_checker.sv
dv/json_string_unescape_test.sv
